@@ rtl/mnpt_pkg.sv @@
// Package for the MIDI note pairing tracker: widths, codes, defaults.
// No dependencies.
package mnpt_pkg;
  localparam int TickW    = 31;
  localparam int PitchW   = 7;
  localparam int Pitches  = 128;
  localparam logic [30:0] TickMax = 31'h7fffffff;
  localparam int DefChannels   = 16;
  localparam int DefQueueDepth = 4;
  localparam logic [15:0] TpqReset = 16'd480;

  localparam logic [1:0] OpCtl   = 2'd0;
  localparam logic [1:0] OpOn    = 2'd1;
  localparam logic [1:0] OpOff   = 2'd2;
  localparam logic [1:0] OpDrain = 2'd3;

  localparam logic [7:0] CtlBankHi = 8'd0;
  localparam logic [7:0] CtlBankLo = 8'd32;
  localparam logic [7:0] CtlProg   = 8'd129;

  localparam logic [1:0] StOff   = 2'd0;
  localparam logic [1:0] StDrain = 2'd1;
  localparam logic [1:0] StDrop  = 2'd2;

  // controller -> datapath commands
  typedef struct packed {
    logic cap;     // capture the input beat
    logic rd;      // read key state (head, count)
    logic rde;     // read queue entry at head
    logic push;    // write entry, bump count
    logic pop;     // emit head entry, advance head
    logic drop;    // emit dropped note
    logic ctl;     // apply controller
    logic clr;     // clearing pass step
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] op;
    logic valid;    // channel/pitch in range
    logic note_on;  // op on with velocity > 0
    logic empty;
    logic full;
    logic last_pop; // count is one
    logic clr_done;
  } stat_t;
endpackage

@@ rtl/midi_note_pairing_tracker_core.sv @@
// Top level of the MIDI note pairing tracker: controller plus datapath.
// Depends on mnpt_pkg, mnpt_ctrl, mnpt_datapath.
//
// Beats enter on start while busy is low. A controller beat, or a beat whose
// channel or pitch is out of range, ends after capture and key state read;
// note on/off steps through capture, key state read, head entry read and act;
// a drain does too and repeats entry read and act per further closed note.
// The per-key queue state and entry memories (one registered read port each)
// set these steps. Each result shows for one cycle with out_valid, the cycle
// after its act step; the receiver cannot stall, so results never wait.
// After reset a clearing pass, busy high, zeroes all CHANNELS*128 key states;
// ticks_per_quarter writes take effect at once, so write only while idle.
module midi_note_pairing_tracker_core import mnpt_pkg::*; #(
  parameter int CHANNELS = DefChannels,
  parameter int QUEUE_DEPTH = DefQueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [30:0] in_tick,
  input  logic [3:0]  in_channel,
  input  logic [7:0]  in_number,
  input  logic [7:0]  in_data_value,
  input  logic [7:0]  in_staff,
  input  logic [1:0]  in_voice,
  input  logic [15:0] in_measure,
  input  logic [9:0]  in_page,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [30:0] out_start_tick,
  output logic [30:0] out_end_tick,
  output logic [6:0]  out_velocity,
  output logic [6:0]  out_program_res,
  output logic [13:0] out_bank,
  output logic [7:0]  out_staff_out,
  output logic [1:0]  out_voice_out,
  output logic [15:0] out_measure_out,
  output logic [9:0]  out_page_out,
  output logic        out_last
);
  cmd_t  cmd;
  stat_t st;

  mnpt_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .st, .cmd);

  mnpt_datapath #(.CHANNELS(CHANNELS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .st,
    .in_opcode, .in_tick, .in_channel, .in_number, .in_data_value,
    .in_staff, .in_voice, .in_measure, .in_page, .cfg_we, .cfg_data,
    .out_valid, .out_status, .out_start_tick, .out_end_tick, .out_velocity,
    .out_program_res, .out_bank, .out_staff_out, .out_voice_out,
    .out_measure_out, .out_page_out, .out_last
  );
endmodule

@@ rtl/mnpt_datapath.sv @@
// Datapath: channel bank/program, per-key head/count memory, note entry memory.
// Depends on mnpt_pkg.
module mnpt_datapath import mnpt_pkg::*; #(
  parameter int CHANNELS = DefChannels,
  parameter int QUEUE_DEPTH = DefQueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic [1:0]  in_opcode,
  input  logic [30:0] in_tick,
  input  logic [3:0]  in_channel,
  input  logic [7:0]  in_number,
  input  logic [7:0]  in_data_value,
  input  logic [7:0]  in_staff,
  input  logic [1:0]  in_voice,
  input  logic [15:0] in_measure,
  input  logic [9:0]  in_page,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [30:0] out_start_tick,
  output logic [30:0] out_end_tick,
  output logic [6:0]  out_velocity,
  output logic [6:0]  out_program_res,
  output logic [13:0] out_bank,
  output logic [7:0]  out_staff_out,
  output logic [1:0]  out_voice_out,
  output logic [15:0] out_measure_out,
  output logic [9:0]  out_page_out,
  output logic        out_last
);
  localparam int ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int Keys  = CHANNELS * Pitches;
  localparam int KeyW  = $clog2(Keys);
  localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  // entry slots per key rounded up to a power of two so {key, slot} addresses
  localparam int Ents  = (QUEUE_DEPTH > 1) ? (Keys << QW) : Keys;
  localparam int EntW  = (QUEUE_DEPTH > 1) ? KeyW + QW : KeyW;
  localparam int EW    = 31 + 7 + 7 + 14 + 8 + 2 + 16 + 10;
  localparam int KsW   = QW + CntW;

  logic [1:0]  op_r;
  logic [30:0] tick_r;
  logic [3:0]  ch_r;
  logic [7:0]  num_r, val_r, staff_r;
  logic [1:0]  voice_r;
  logic [15:0] meas_r;
  logic [9:0]  page_r;
  logic [15:0] tpq_r;

  logic [13:0] bank_r [CHANNELS];
  logic [6:0]  prog_r [CHANNELS];
  logic [KsW-1:0] kmem [Keys];
  logic [EW-1:0]  emem [Ents];
  logic [KsW-1:0] ks_r;
  logic [EW-1:0]  ent_r;
  logic [KeyW-1:0] clr_r;

  logic [ChW-1:0]  ch;
  logic [KeyW-1:0] key;
  logic [QW-1:0]   head, tail, head_nx;
  logic [CntW-1:0] cnt;
  logic [EntW-1:0] raddr, waddr;
  logic [6:0]      vsat, vel;
  logic [EW-1:0]   wentry;
  logic [KsW-1:0]  ks_pop;

  assign ch   = ChW'(ch_r);
  assign key  = KeyW'({ch_r, 7'd0} + {4'd0, num_r[6:0]});
  assign head = ks_r[KsW-1 -: QW];
  assign cnt  = ks_r[CntW-1:0];
  assign vsat = val_r[7] ? 7'd127 : val_r[6:0];
  assign vel  = vsat;

  always_comb begin
    logic [QW:0] s;
    s = {1'b0, head} + {1'b0, cnt[QW-1:0]};
    if (QUEUE_DEPTH == 1) tail = '0;
    else if (s >= (QW+1)'(QUEUE_DEPTH)) tail = QW'(s - (QW+1)'(QUEUE_DEPTH));
    else tail = s[QW-1:0];
    if (QUEUE_DEPTH == 1 || head == QW'(QUEUE_DEPTH - 1)) head_nx = '0;
    else head_nx = head + 1'b1;
  end

  // key state after popping the head; an emptied key goes back to head 0
  assign ks_pop = (cnt == CntW'(1)) ? '0 : {head_nx, CntW'(cnt - 1'b1)};

  if (QUEUE_DEPTH > 1) begin : g_addr
    assign raddr = {key, head};
    assign waddr = {key, tail};
  end else begin : g_addr1
    assign raddr = key;
    assign waddr = key;
  end

  assign wentry = {tick_r, vel, prog_r[ch], bank_r[ch], staff_r, voice_r, meas_r, page_r};

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r <= in_opcode; tick_r <= in_tick; ch_r <= in_channel;
      num_r <= in_number; val_r <= in_data_value; staff_r <= in_staff;
      voice_r <= in_voice; meas_r <= in_measure; page_r <= in_page;
    end
    // head entry is read in the cycle after the key state, from the loaded head
    if (cmd.rd) ks_r <= kmem[key];
    else if (cmd.pop) ks_r <= ks_pop;
    if (cmd.rde) ent_r <= emem[raddr];
    if (cmd.clr) kmem[clr_r] <= '0;
    else if (cmd.push) kmem[key] <= {head, CntW'(cnt + 1'b1)};
    else if (cmd.pop) kmem[key] <= ks_pop;
    if (cmd.push) emem[waddr] <= wentry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpq_r <= TpqReset;
      clr_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        bank_r[i] <= '0; prog_r[i] <= '0;
      end
    end else begin
      if (cfg_we) tpq_r <= cfg_data;
      if (cmd.clr) clr_r <= clr_r + 1'b1;
      if (cmd.ctl) begin
        if (num_r == CtlBankHi) bank_r[ch] <= {vsat, bank_r[ch][6:0]};
        else if (num_r == CtlBankLo) bank_r[ch] <= {bank_r[ch][13:7], vsat};
        else if (num_r == CtlProg) prog_r[ch] <= vsat;
      end
    end
  end

  assign st.op       = op_r;
  assign st.valid    = (32'(ch_r) < CHANNELS) && (op_r == OpCtl || !num_r[7]);
  assign st.note_on  = (op_r == OpOn) && (val_r != 8'd0);
  assign st.empty    = (cnt == '0);
  assign st.full     = (32'(cnt) >= QUEUE_DEPTH);
  assign st.last_pop = (cnt == CntW'(1));
  assign st.clr_done = (clr_r == KeyW'(Keys - 1));

  // result register
  logic [30:0] es;
  logic [31:0] sum;
  always_comb begin
    es = ent_r[EW-1 -: 31];
    if (op_r == OpDrain) sum = {1'b0, es} + {16'd0, tpq_r};
    else begin
      sum = {1'b0, es} + 32'd1;
      if (sum[31]) sum = {1'b0, TickMax};
      if ({1'b0, tick_r} > sum) sum = {1'b0, tick_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= cmd.pop | cmd.drop;
    if (cmd.drop) begin
      out_status <= StDrop; out_start_tick <= tick_r; out_end_tick <= '0;
      out_velocity <= vel; out_program_res <= prog_r[ch]; out_bank <= bank_r[ch];
      out_staff_out <= staff_r; out_voice_out <= voice_r;
      out_measure_out <= meas_r; out_page_out <= page_r; out_last <= 1'b1;
    end else if (cmd.pop) begin
      out_status <= (op_r == OpDrain) ? StDrain : StOff;
      out_start_tick <= es;
      out_end_tick <= sum[31] ? TickMax : sum[30:0];
      {out_velocity, out_program_res, out_bank, out_staff_out, out_voice_out,
       out_measure_out, out_page_out} <= ent_r[EW-32:0];
      out_last <= (op_r != OpDrain) || (cnt == CntW'(1));
    end
  end
endmodule

@@ rtl/mnpt_ctrl.sv @@
// Controller FSM: sequences capture, memory read, write-back and result beats.
// Depends on mnpt_pkg.
module mnpt_ctrl import mnpt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  stat_t st,
  output cmd_t  cmd
);
  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_RD   = 6'b000100,
    S_ENT  = 6'b001000,
    S_ACT  = 6'b010000,
    S_WAIT = 6'b100000
  } state_t;
  state_t state_r, state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: if (start) begin
        cmd.cap = 1'b1; state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd = 1'b1; state_nxt = S_ENT;
        if (!st.valid) state_nxt = S_IDLE;
        else if (st.op == OpCtl) begin
          cmd.ctl = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_ENT: begin
        cmd.rde = 1'b1; state_nxt = S_ACT;
      end
      S_ACT: begin
        state_nxt = S_IDLE;
        if (st.note_on) begin
          if (st.full) cmd.drop = 1'b1;
          else cmd.push = 1'b1;
        end else if (!st.empty) begin
          cmd.pop = 1'b1;
          if (st.op == OpDrain && !st.last_pop) state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        cmd.rde = 1'b1; state_nxt = S_ACT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push && cmd.pop) && !(cmd.drop && cmd.pop))
    else $error("conflicting commands");
  a_cap: assert property (@(posedge clk) disable iff (!rst_n) cmd.cap |=> state_r == S_RD)
    else $error("capture not followed by read");
`endif
endmodule

@@ test/midi_note_pairing_tracker_core_tb.sv @@
// Self-checking testbench for midi_note_pairing_tracker_core: a directed table,
// then random phases of note traffic checked against an in-bench note tracker.
// Depends on mnpt_pkg and the RTL top level only.
module midi_note_pairing_tracker_core_tb;
  import mnpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One input beat, field by field at port widths.
  typedef struct packed {
    logic [1:0]  op;
    logic [30:0] tick;
    logic [3:0]  ch;
    logic [7:0]  num;
    logic [7:0]  val;
    logic [7:0]  staff;
    logic [1:0]  voice;
    logic [15:0] measure;
    logic [9:0]  page;
  } beat_t;

  // One closed (or dropped) note as it leaves the block.
  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] start_tick;
    logic [30:0] stop_tick;
    logic [6:0]  vel;
    logic [6:0]  prog;
    logic [13:0] bank;
    logic [7:0]  staff;
    logic [1:0]  voice;
    logic [15:0] measure;
    logic [9:0]  page;
    logic        last;
  } note_rec_t;

  // Directed table row; typed rows carry the single note they must close.
  typedef struct packed {
    beat_t     b;
    logic      typed;
    note_rec_t want;
  } row_t;

  localparam int Keys      = DefChannels * Pitches;
  localparam int Depth     = DefQueueDepth;
  localparam int Settle    = 20;  // covers a beat that closes no note
  localparam int NumRows   = 24;
  localparam int RandBeats = 300;
  localparam int OwedSize  = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_opcode = '0;
  logic [30:0] in_tick = '0;
  logic [3:0]  in_channel = '0;
  logic [7:0]  in_number = '0;
  logic [7:0]  in_data_value = '0;
  logic [7:0]  in_staff = '0;
  logic [1:0]  in_voice = '0;
  logic [15:0] in_measure = 16'd1;
  logic [9:0]  in_page = '0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [30:0] out_start_tick;
  logic [30:0] out_end_tick;
  logic [6:0]  out_velocity;
  logic [6:0]  out_program_res;
  logic [13:0] out_bank;
  logic [7:0]  out_staff_out;
  logic [1:0]  out_voice_out;
  logic [15:0] out_measure_out;
  logic [9:0]  out_page_out;
  logic        out_last;

  midi_note_pairing_tracker_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_tick(in_tick), .in_channel(in_channel),
    .in_number(in_number), .in_data_value(in_data_value), .in_staff(in_staff),
    .in_voice(in_voice), .in_measure(in_measure), .in_page(in_page),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_status(out_status),
    .out_start_tick(out_start_tick), .out_end_tick(out_end_tick),
    .out_velocity(out_velocity), .out_program_res(out_program_res),
    .out_bank(out_bank), .out_staff_out(out_staff_out),
    .out_voice_out(out_voice_out), .out_measure_out(out_measure_out),
    .out_page_out(out_page_out), .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracker state: per-channel bank/program, per-key FIFO of pending notes.
  logic [15:0] tpq_shadow;
  logic [13:0] chan_bank [DefChannels];
  logic [6:0]  chan_prog [DefChannels];
  int          key_head  [Keys];
  int          key_count [Keys];
  note_rec_t   pending   [Keys][Depth];

  note_rec_t   owed [OwedSize];   // ring of notes the block still owes us
  int          owed_wr = 0;
  int          owed_rd = 0;
  note_rec_t   fresh [Depth];     // notes caused by the beat just accepted
  int          fresh_n = 0;
  int          errors = 0;
  logic [30:0] clock_tick = '0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  function automatic logic [30:0] tick_sat_add(input logic [30:0] a,
                                               input logic [30:0] b);
    logic [31:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[31] ? TickMax : s[30:0];
  endfunction

  function automatic logic [6:0] clip7(input logic [7:0] v);
    return v[7] ? 7'h7f : v[6:0];
  endfunction

  task automatic add_fresh(input note_rec_t n);
    fresh[fresh_n] = n;
    fresh_n++;
  endtask

  task automatic book_note(input note_rec_t n);
    owed[owed_wr % OwedSize] = n;
    owed_wr++;
  endtask

  // Apply one accepted beat to the tracker; caused notes land in fresh.
  task automatic track_beat(input beat_t b);
    int        key;
    note_rec_t n;
    logic [30:0] fin;
    fresh_n = 0;
    if (b.op == OpCtl) begin
      if (b.num == CtlBankHi) chan_bank[b.ch][13:7] = clip7(b.val);
      else if (b.num == CtlBankLo) chan_bank[b.ch][6:0] = clip7(b.val);
      else if (b.num == CtlProg) chan_prog[b.ch] = clip7(b.val);
      return;
    end
    if (b.num[7]) return;  // pitch out of range: ignored
    key = b.ch * Pitches + b.num;
    if (b.op == OpOn && b.val != 0) begin
      n = '{status: StDrop, start_tick: b.tick, stop_tick: '0, vel: clip7(b.val),
            prog: chan_prog[b.ch], bank: chan_bank[b.ch], staff: b.staff,
            voice: b.voice, measure: b.measure, page: b.page, last: 1'b1};
      if (key_count[key] >= Depth) begin
        add_fresh(n);
      end else begin
        pending[key][(key_head[key] + key_count[key]) % Depth] = n;
        key_count[key]++;
      end
    end else if (b.op == OpOn || b.op == OpOff) begin
      if (key_count[key] == 0) return;  // unpaired note off
      n = pending[key][key_head[key]];
      fin = tick_sat_add(n.start_tick, 31'd1);
      n.stop_tick = (b.tick > fin) ? b.tick : fin;
      n.status = StOff;
      n.last = 1'b1;
      add_fresh(n);
      key_head[key] = (key_head[key] + 1) % Depth;
      key_count[key]--;
    end else begin
      while (key_count[key] > 0) begin
        n = pending[key][key_head[key]];
        n.status = StDrain;
        n.stop_tick = tick_sat_add(n.start_tick, {15'd0, tpq_shadow});
        n.last = (key_count[key] == 1);
        add_fresh(n);
        key_head[key] = (key_head[key] + 1) % Depth;
        key_count[key]--;
      end
      key_head[key] = 0;
    end
  endtask

  // Present a beat after a gap, hold start until taken, then book its notes.
  // Entered just after a rising edge, so all drives land at the edge.
  task automatic drive_beat(input beat_t b, input int gap, input logic typed,
                            input note_rec_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_opcode     <= b.op;
    in_tick       <= b.tick;
    in_channel    <= b.ch;
    in_number     <= b.num;
    in_data_value <= b.val;
    in_staff      <= b.staff;
    in_voice      <= b.voice;
    in_measure    <= b.measure;
    in_page       <= b.page;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    track_beat(b);
    if (typed) begin
      if (fresh_n != 1) report_mismatch("table note count", 32'(fresh_n), 32'd1);
      book_note(want);
    end else begin
      for (int i = 0; i < fresh_n; i++) book_note(fresh[i]);
    end
  endtask

  // Drain everything owed, then let a beat with no result finish too.
  task automatic wait_idle();
    start <= 1'b0;
    while (owed_wr != owed_rd) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_tpq(input logic [15:0] v);
    cfg_data <= v;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    tpq_shadow = v;
  endtask

  function automatic beat_t mk(input logic [1:0] op, input logic [30:0] tick,
                               input logic [3:0] ch, input logic [7:0] num,
                               input logic [7:0] val, input logic [7:0] staff,
                               input logic [1:0] voice, input logic [15:0] meas,
                               input logic [9:0] page);
    return '{op, tick, ch, num, val, staff, voice, meas, page};
  endfunction

  // Random beat aimed at a few hot keys so FIFOs fill, pair and drain.
  function automatic beat_t rand_beat();
    beat_t b;
    int    r;
    r = $urandom_range(0, 99);
    b.op = (r < 15) ? OpCtl : (r < 58) ? OpOn : (r < 88) ? OpOff : OpDrain;
    clock_tick = clock_tick + 31'($urandom_range(0, 600));
    b.tick = ($urandom_range(0, 19) == 0) ? 31'($urandom) : clock_tick;
    b.ch = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
    b.num = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                        : 8'(60 + $urandom_range(0, 3));
    if (b.op == OpCtl) begin
      case ($urandom_range(0, 3))
        0: b.num = CtlBankHi;
        1: b.num = CtlBankLo;
        2: b.num = CtlProg;
        default: b.num = 8'($urandom);
      endcase
    end
    b.val = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
    b.staff = 8'($urandom);
    b.voice = 2'($urandom);
    b.measure = 16'($urandom);
    b.page = 10'($urandom);
    return b;
  endfunction

  // Result checker: every strobed note against the oldest owed note.
  always @(posedge clk) begin
    note_rec_t w;
    if (rst_n && out_valid) begin
      if (owed_wr == owed_rd) begin
        report_mismatch("unexpected note, status", 32'(out_status), 32'd0);
      end else begin
        w = owed[owed_rd % OwedSize];
        owed_rd++;
        if (out_status != w.status)
          report_mismatch("status", 32'(out_status), 32'(w.status));
        if (out_start_tick != w.start_tick)
          report_mismatch("start_tick", 32'(out_start_tick), 32'(w.start_tick));
        if (out_end_tick != w.stop_tick)
          report_mismatch("end tick", 32'(out_end_tick), 32'(w.stop_tick));
        if (out_velocity != w.vel)
          report_mismatch("velocity", 32'(out_velocity), 32'(w.vel));
        if (out_program_res != w.prog)
          report_mismatch("program", 32'(out_program_res), 32'(w.prog));
        if (out_bank != w.bank) report_mismatch("bank", 32'(out_bank), 32'(w.bank));
        if (out_staff_out != w.staff)
          report_mismatch("staff", 32'(out_staff_out), 32'(w.staff));
        if (out_voice_out != w.voice)
          report_mismatch("voice", 32'(out_voice_out), 32'(w.voice));
        if (out_measure_out != w.measure)
          report_mismatch("measure", 32'(out_measure_out), 32'(w.measure));
        if (out_page_out != w.page)
          report_mismatch("page", 32'(out_page_out), 32'(w.page));
        if (out_last != w.last) report_mismatch("last", 32'(out_last), 32'(w.last));
      end
    end
  end

  row_t        rows [NumRows];
  logic [15:0] tpq_plan [5] = '{16'd0, 16'hffff, 16'd1, 16'd37, TpqReset};

  initial begin
    note_rec_t nil;
    nil = '0;
    tpq_shadow = TpqReset;
    foreach (chan_bank[i]) begin
      chan_bank[i] = '0;
      chan_prog[i] = '0;
    end
    foreach (key_head[i]) begin
      key_head[i] = 0;
      key_count[i] = 0;
    end

    // Directed table: empty-key cases, controller saturation, extremes,
    // full FIFO drop, velocity-zero off, saturating end tick, ignored pitches.
    rows[0]  = '{mk(OpOff, 31'd10, 4'd0, 8'd60, 8'd64, 8'd0, 2'd0, 16'd1, 10'd0), 0, nil};
    rows[1]  = '{mk(OpDrain, 31'd10, 4'd0, 8'd60, 8'd0, 8'd0, 2'd0, 16'd1, 10'd0), 0, nil};
    rows[2]  = '{mk(OpCtl, 31'd0, 4'd1, CtlBankHi, 8'd255, 8'd0, 2'd0, 16'd1, 10'd0), 0, nil};
    rows[3]  = '{mk(OpCtl, 31'd0, 4'd1, CtlBankLo, 8'd5, 8'd0, 2'd0, 16'd1, 10'd0), 0, nil};
    rows[4]  = '{mk(OpCtl, 31'd0, 4'd1, CtlProg, 8'd200, 8'd0, 2'd0, 16'd1, 10'd0), 0, nil};
    rows[5]  = '{mk(OpCtl, 31'd0, 4'd1, 8'd7, 8'd9, 8'd0, 2'd0, 16'd1, 10'd0), 0, nil};
    rows[6]  = '{mk(OpOn, 31'd100, 4'd1, 8'd127, 8'd255, 8'd255, 2'd3, 16'hffff, 10'h3ff),
                 0, nil};
    // off before start: end clamps to start + 1; bank is 127 high, 5 low
    rows[7]  = '{mk(OpOff, 31'd50, 4'd1, 8'd127, 8'd0, 8'd0, 2'd0, 16'd1, 10'd0), 1,
                 '{StOff, 31'd100, 31'd101, 7'd127, 7'd127, 14'h3f85, 8'd255, 2'd3,
                   16'hffff, 10'h3ff, 1'b1}};
    rows[8]  = '{mk(OpOn, 31'd0, 4'd2, 8'd0, 8'd1, 8'd1, 2'd0, 16'd1, 10'd1), 0, nil};
    rows[9]  = '{mk(OpOn, 31'd1, 4'd2, 8'd0, 8'd2, 8'd2, 2'd1, 16'd2, 10'd2), 0, nil};
    rows[10] = '{mk(OpOn, 31'd2, 4'd2, 8'd0, 8'd3, 8'd3, 2'd2, 16'd3, 10'd3), 0, nil};
    rows[11] = '{mk(OpOn, 31'd3, 4'd2, 8'd0, 8'd4, 8'd4, 2'd3, 16'd4, 10'd4), 0, nil};
    // fifth note on the same key: dropped, end tick zero
    rows[12] = '{mk(OpOn, 31'd7, 4'd2, 8'd0, 8'd9, 8'd5, 2'd1, 16'd5, 10'd5), 1,
                 '{StDrop, 31'd7, 31'd0, 7'd9, 7'd0, 14'd0, 8'd5, 2'd1, 16'd5,
                   10'd5, 1'b1}};
    rows[13] = '{mk(OpOn, 31'd500, 4'd2, 8'd0, 8'd0, 8'd0, 2'd0, 16'd1, 10'd0), 0, nil};
    rows[14] = '{mk(OpDrain, 31'd0, 4'd2, 8'd0, 8'd0, 8'd0, 2'd0, 16'd1, 10'd0), 0, nil};
    rows[15] = '{mk(OpOn, 31'd9, 4'd4, 8'd200, 8'd64, 8'd0, 2'd0, 16'd1, 10'd0), 0, nil};
    rows[16] = '{mk(OpOff, 31'd9, 4'd4, 8'd128, 8'd0, 8'd0, 2'd0, 16'd1, 10'd0), 0, nil};
    rows[17] = '{mk(OpDrain, 31'd9, 4'd4, 8'd255, 8'd0, 8'd0, 2'd0, 16'd1, 10'd0), 0, nil};
    rows[18] = '{mk(OpOn, TickMax, 4'd3, 8'd5, 8'd64, 8'd0, 2'd0, 16'd1, 10'd0), 0, nil};
    // start at max tick: start + 1 saturates
    rows[19] = '{mk(OpOff, 31'd0, 4'd3, 8'd5, 8'd0, 8'd0, 2'd0, 16'd1, 10'd0), 1,
                 '{StOff, TickMax, TickMax, 7'd64, 7'd0, 14'd0, 8'd0, 2'd0, 16'd1,
                   10'd0, 1'b1}};
    rows[20] = '{mk(OpOn, 31'h7ffffe00, 4'd15, 8'd64, 8'd127, 8'd7, 2'd2, 16'd9, 10'd9),
                 0, nil};
    rows[21] = '{mk(OpOn, 31'd20, 4'd15, 8'd64, 8'd128, 8'd8, 2'd1, 16'd8, 10'd8), 0, nil};
    rows[22] = '{mk(OpDrain, 31'd0, 4'd15, 8'd64, 8'd0, 8'd0, 2'd0, 16'd1, 10'd0), 0, nil};
    rows[23] = '{mk(OpOff, 31'h7fffffff, 4'd15, 8'd64, 8'd0, 8'd0, 2'd0, 16'd1, 10'd0),
                 0, nil};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i])
      drive_beat(rows[i].b, $urandom_range(0, 3), rows[i].typed, rows[i].want);
    wait_idle();

    // Random phases, each under its own ticks-per-quarter; the pause before
    // every write also holds the sender off until all notes are out.
    foreach (tpq_plan[p]) begin
      write_tpq(p == 3 ? 16'($urandom_range(1, 65535)) : tpq_plan[p]);
      for (int i = 0; i < RandBeats / 5; i++)
        drive_beat(rand_beat(), ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16),
                   1'b0, nil);
      wait_idle();
    end

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
